// File: hw/rtl/mqrr_pkg.sv
// shared widths, operation and status codes, config register indexes
// for the round-robin multi-queue dispatcher; no dependencies
package mqrr_pkg;

  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned DEST_BITS   = 4;
  localparam int unsigned HANDLE_PORT_BITS = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned MASK_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS = 4;

  // operation codes
  localparam logic [OPCODE_BITS-1:0] OP_PUSH = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_POP  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_PICK = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_DEST = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENT = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORKER  = 4'd1;

  // outcome of the round-robin search
  typedef struct packed {
    logic                 found;
    logic [DEST_BITS-1:0] id;
  } pick_res_t;

endpackage

// File: hw/rtl/mqrr_if.sv
// request, response and config channel interfaces of the dispatcher
// depends on mqrr_pkg for payload widths
interface mqrr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [mqrr_pkg::OPCODE_BITS-1:0]      opcode;
  logic [mqrr_pkg::DEST_BITS-1:0]        dest_id;
  logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] message_handle;

  modport source (output valid, opcode, dest_id, message_handle, input ready);
  modport sink (input valid, opcode, dest_id, message_handle, output ready);
endinterface

interface mqrr_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [mqrr_pkg::STATUS_BITS-1:0]      status;
  logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] popped_handle;
  logic [mqrr_pkg::DEST_BITS-1:0]        picked_id;

  modport source (output valid, status, popped_handle, picked_id, input ready);
  modport sink (input valid, status, popped_handle, picked_id, output ready);
endinterface

interface mqrr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mqrr_pkg::CFG_IDX_BITS-1:0] index;
  logic [mqrr_pkg::MASK_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/mqrr_slot_ram.sv
// handle storage of all destination fifos, one write and one read port
// registered read data; no dependencies
module mqrr_slot_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mqrr_ptr_ram.sv
// per-destination head, tail and count entries, registered read port
// entries never written read as zero through per-entry valid bits; no dependencies
module mqrr_ptr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written_q;
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= written_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mqrr_rr_pick.sv
// rotating priority encoder over the busy worker destinations
// depends on mqrr_pkg for the result struct
module mqrr_rr_pick #(
  parameter int unsigned NUM = 16
) (
  input  logic [NUM-1:0]                  cand_i,
  input  logic [mqrr_pkg::DEST_BITS-1:0]  cursor_i,
  output mqrr_pkg::pick_res_t             res_o
);

  localparam int unsigned IW = $clog2(NUM);
  localparam logic [4:0] NumW = 5'(NUM);

  always_comb begin
    logic [4:0] sum;
    logic [4:0] id;
    res_o = '0;
    // walk from farthest to nearest so the nearest hit wins
    for (int k = NUM; k >= 1; k--) begin
      sum = 5'(cursor_i) + 5'(k);
      id  = (sum >= NumW) ? sum - NumW : sum;
      if (cand_i[id[IW-1:0]]) begin
        res_o.found = 1'b1;
        res_o.id    = id[mqrr_pkg::DEST_BITS-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/multi_queue_round_robin_dispatcher.sv
// flow: a request is taken only in S_IDLE, which starts the pointer memory read; S_PTR
//   writes the entry back, a successful pop reads the slot memory for S_SLOT, then the
//   response is loaded and S_IDLE returns; an untaken response stalls S_PTR or S_SLOT
// reset: control, masks, cursor and busy flags clear at once; pointer entries read as
//   zero until first written; no clearing pass, the slot memory is never cleared
module multi_queue_round_robin_dispatcher #(
  parameter int unsigned NUM_DEST    = 16,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mqrr_req_if.sink           req_i,
  mqrr_rsp_if.source         rsp_o,
  mqrr_cfg_if.sink           cfg_i
);

  // only ids below 16 can ever be present, so at most 16 queues are built
  localparam int unsigned ND   = (NUM_DEST < 16) ? NUM_DEST : 16;
  // handles arrive on a 32 bit port, so no more than 32 bits are ever stored
  localparam int unsigned HB   = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int unsigned AW   = $clog2(ND);
  localparam int unsigned PTRW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PEW  = CW + 2 * PTRW;
  localparam int unsigned SD   = ND * QUEUE_DEPTH;
  localparam int unsigned SAW  = $clog2(SD);
  localparam logic [PTRW-1:0] LastIdx = PTRW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]   FullCnt = CW'(QUEUE_DEPTH);
  localparam logic [4:0]      NdW     = 5'(ND);

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a request
    S_PTR,   // pointer entry of the addressed queue is on the read port
    S_SLOT   // popped handle is on the slot read port
  } state_e;

  state_e                               state_q;
  logic [mqrr_pkg::OPCODE_BITS-1:0]     op_q;
  logic [mqrr_pkg::DEST_BITS-1:0]       dest_q;
  logic [HB-1:0]                        handle_q;
  logic [mqrr_pkg::MASK_BITS-1:0]       present_q;
  logic [mqrr_pkg::MASK_BITS-1:0]       worker_q;
  logic [mqrr_pkg::DEST_BITS-1:0]       cursor_q;
  // one busy flag per queue mirrors count != 0 so the picker sees all at once
  logic [ND-1:0]                        busy_q;

  // response register, parts the request side from the response side
  logic                                 rsp_valid_q;
  logic                                 rsp_valid_d;
  logic [mqrr_pkg::STATUS_BITS-1:0]     status_q;
  logic [HB-1:0]                        popped_q;
  logic [mqrr_pkg::DEST_BITS-1:0]       picked_q;

  logic                                 req_fire;
  logic                                 out_free;
  logic [AW-1:0]                        didx;
  logic                                 dest_ok;
  logic                                 push_ok;
  logic                                 pop_ok;

  logic [PEW-1:0]                       ptr_rdata;
  logic [PEW-1:0]                       ptr_wdata;
  logic                                 ptr_we;
  logic [PTRW-1:0]                      head;
  logic [PTRW-1:0]                      tail;
  logic [CW-1:0]                        count;
  logic [PTRW-1:0]                      head_nxt;
  logic [PTRW-1:0]                      tail_nxt;

  logic                                 slot_we;
  logic                                 slot_re;
  logic [SAW-1:0]                       slot_addr;
  logic [HB-1:0]                        slot_rdata;

  logic [ND-1:0]                        cand;
  mqrr_pkg::pick_res_t                  pick;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // config writes are always taken; unknown indexes are ignored
  assign cfg_i.ready = 1'b1;

  assign didx    = dest_q[AW-1:0];
  assign dest_ok = (5'(dest_q) < NdW) && present_q[dest_q];

  // pointer entry layout: {count, tail, head}
  assign head  = ptr_rdata[PTRW-1:0];
  assign tail  = ptr_rdata[2*PTRW-1:PTRW];
  assign count = ptr_rdata[PEW-1:2*PTRW];

  assign head_nxt = (head == LastIdx) ? '0 : head + 1'b1;
  assign tail_nxt = (tail == LastIdx) ? '0 : tail + 1'b1;

  assign push_ok = dest_ok && (count != FullCnt);
  assign pop_ok  = dest_ok && (count != '0);

  // a push writes back only when its response can be loaded, as the state
  // stays in S_PTR until then; a pop writes back at once and moves on
  assign slot_we = (state_q == S_PTR) && (op_q == mqrr_pkg::OP_PUSH) && push_ok && out_free;
  assign slot_re = (state_q == S_PTR) && (op_q == mqrr_pkg::OP_POP) && pop_ok;
  assign ptr_we  = slot_we || slot_re;

  always_comb begin
    if (op_q == mqrr_pkg::OP_PUSH) begin
      ptr_wdata = {count + 1'b1, tail_nxt, head};
    end else begin
      ptr_wdata = {count - 1'b1, tail, head_nxt};
    end
  end

  // queue d owns slots d*QUEUE_DEPTH .. d*QUEUE_DEPTH+QUEUE_DEPTH-1
  assign slot_addr = SAW'(didx) * SAW'(QUEUE_DEPTH)
                   + SAW'((op_q == mqrr_pkg::OP_PUSH) ? tail : head);

  // the write back of one request lands before the next request is accepted,
  // so a pointer read never needs forwarding
  mqrr_ptr_ram #(
    .DEPTH (ND),
    .WIDTH (PEW)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ptr_we),
    .waddr_i (didx),
    .wdata_i (ptr_wdata),
    .re_i    (req_fire),
    .raddr_i (req_i.dest_id[AW-1:0]),
    .rdata_o (ptr_rdata)
  );

  mqrr_slot_ram #(
    .DEPTH (SD),
    .WIDTH (HB)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_addr),
    .wdata_i (handle_q),
    .re_i    (slot_re),
    .raddr_i (slot_addr),
    .rdata_o (slot_rdata)
  );

  // only present workers with queued handles can be picked
  assign cand = busy_q & present_q[ND-1:0] & worker_q[ND-1:0];

  mqrr_rr_pick #(
    .NUM (ND)
  ) u_rr_pick (
    .cand_i   (cand),
    .cursor_i (cursor_q),
    .res_o    (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      worker_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mqrr_pkg::CFG_PRESENT: present_q <= cfg_i.data;
        mqrr_pkg::CFG_WORKER:  worker_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q     <= req_i.opcode;
      dest_q   <= req_i.dest_id;
      handle_q <= HB'(req_i.message_handle);
    end
  end

  // busy flags follow the count of each queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (slot_we) begin
      busy_q[didx] <= 1'b1;
    end else if (slot_re && (count == CW'(1))) begin
      busy_q[didx] <= 1'b0;
    end
  end

  // response valid: loaded when a request finishes, dropped once taken
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (out_free) begin
      rsp_valid_d = 1'b0;
    end
    if (out_free && ((state_q == S_SLOT) ||
        ((state_q == S_PTR) && !((op_q == mqrr_pkg::OP_POP) && pop_ok)))) begin
      rsp_valid_d = 1'b1;
    end
  end

  // control sequencer with the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= mqrr_pkg::ST_OK;
      popped_q    <= '0;
      picked_q    <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            state_q <= S_PTR;
          end
        end
        S_PTR: begin
          if ((op_q == mqrr_pkg::OP_POP) && pop_ok) begin
            state_q <= S_SLOT;
          end else if (out_free) begin
            state_q     <= S_IDLE;
            popped_q    <= '0;
            picked_q    <= '0;
            case (op_q)
              mqrr_pkg::OP_PUSH: begin
                if (!dest_ok) begin
                  status_q <= mqrr_pkg::ST_BAD_DEST;
                end else if (!push_ok) begin
                  status_q <= mqrr_pkg::ST_FULL;
                end else begin
                  status_q <= mqrr_pkg::ST_OK;
                end
              end
              mqrr_pkg::OP_POP: begin
                // a successful pop is finished in S_SLOT
                status_q <= dest_ok ? mqrr_pkg::ST_EMPTY : mqrr_pkg::ST_BAD_DEST;
              end
              mqrr_pkg::OP_PICK: begin
                if (pick.found) begin
                  status_q <= mqrr_pkg::ST_OK;
                  picked_q <= pick.id;
                  cursor_q <= pick.id;
                end else begin
                  status_q <= mqrr_pkg::ST_EMPTY;
                end
              end
              default: begin
                status_q <= mqrr_pkg::ST_BAD_DEST;
              end
            endcase
          end
        end
        S_SLOT: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            status_q    <= mqrr_pkg::ST_OK;
            popped_q    <= slot_rdata;
            picked_q    <= '0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.popped_handle = mqrr_pkg::HANDLE_PORT_BITS'(popped_q);
  assign rsp_o.picked_id     = picked_q;

  // busy flag agrees with the stored count of the addressed queue
  a_busy_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) && (5'(dest_q) < NdW) |-> busy_q[didx] == (count != '0))
    else $error("busy flag disagrees with queue count");

  // no queue ever holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) |-> count <= FullCnt)
    else $error("queue count beyond depth");

  // an accepted request always goes to the pointer stage next
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_PTR)
    else $error("accepted request did not reach pointer stage");

  // a slot read is always followed by the stage that returns it
  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_re |=> state_q == S_SLOT)
    else $error("slot read not followed by pop completion");

  // a successful pick names a present worker
  a_pick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) && (op_q == mqrr_pkg::OP_PICK) && pick.found
      |-> present_q[pick.id] && worker_q[pick.id] && (5'(pick.id) < NdW))
    else $error("pick chose a destination that is not a present worker");

endmodule

// File: verif/tb.sv
// self-checking testbench for the round-robin multi-queue dispatcher
// depends on mqrr_pkg, the channel interfaces in mqrr_if.sv and the dispatcher rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned N_DEST      = 16;
  localparam int unsigned Q_DEPTH     = 16;
  localparam int unsigned H_BITS      = 32;
  localparam int unsigned DRAIN_TICKS = 8;        // idle ticks after the last response comes back
  // unused opcode, answered as bad
  localparam logic [mqrr_pkg::OPCODE_BITS-1:0] OP_NONE = 2'd3;

  // one request as the sender sees it
  typedef struct packed {
    logic [mqrr_pkg::OPCODE_BITS-1:0]      op;
    logic [mqrr_pkg::DEST_BITS-1:0]        dest;
    logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] handle;
  } req_rec_t;

  // one response as the dispatcher should return it
  typedef struct packed {
    logic [mqrr_pkg::STATUS_BITS-1:0]      status;
    logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] popped;
    logic [mqrr_pkg::DEST_BITS-1:0]        picked;
  } rsp_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // testbench-side drivers, known from time zero
  logic                                  req_valid = 1'b0;
  logic [mqrr_pkg::OPCODE_BITS-1:0]      req_op = mqrr_pkg::OP_PUSH;
  logic [mqrr_pkg::DEST_BITS-1:0]        req_dest = '0;
  logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] req_handle = '0;
  logic                                  rsp_ready = 1'b1;
  logic                                  cfg_valid = 1'b0;
  logic [mqrr_pkg::CFG_IDX_BITS-1:0]     cfg_index = mqrr_pkg::CFG_PRESENT;
  logic [mqrr_pkg::MASK_BITS-1:0]        cfg_data = '0;

  mqrr_req_if req_if ();
  mqrr_rsp_if rsp_if ();
  mqrr_cfg_if cfg_if ();

  assign req_if.valid          = req_valid;
  assign req_if.opcode         = req_op;
  assign req_if.dest_id        = req_dest;
  assign req_if.message_handle = req_handle;
  assign rsp_if.ready          = rsp_ready;
  assign cfg_if.valid          = cfg_valid;
  assign cfg_if.index          = cfg_index;
  assign cfg_if.data           = cfg_data;

  multi_queue_round_robin_dispatcher #(
    .NUM_DEST   (N_DEST),
    .QUEUE_DEPTH(Q_DEPTH),
    .HANDLE_BITS(H_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // shadow of the dispatcher state, kept by the predictor
  logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] slot_mem   [N_DEST][Q_DEPTH];
  logic [3:0]                            head_ptr   [N_DEST];
  logic [3:0]                            tail_ptr   [N_DEST];
  logic [4:0]                            depth_cnt  [N_DEST];
  logic [mqrr_pkg::DEST_BITS-1:0]        rr_last;
  logic [mqrr_pkg::MASK_BITS-1:0]        present_bits;
  logic [mqrr_pkg::MASK_BITS-1:0]        worker_bits;

  req_rec_t pending_req[$];   // requests not yet handed to the driver
  rsp_rec_t due_rsp[$];       // responses predicted but not yet seen
  bit       holding_req = 1'b0;  // driver owns a request not yet accepted
  int       err_cnt = 0;

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // work out the response of one accepted request and update the shadow state
  task automatic predict_dispatch(input req_rec_t r);
    rsp_rec_t   o;
    logic [3:0] id;
    int         k;
    o = '{status: mqrr_pkg::ST_BAD_DEST, popped: '0, picked: '0};
    case (r.op)
      mqrr_pkg::OP_PUSH: begin
        if (!present_bits[r.dest]) begin
          o.status = mqrr_pkg::ST_BAD_DEST;
        end else if (depth_cnt[r.dest] >= Q_DEPTH) begin
          o.status = mqrr_pkg::ST_FULL;
        end else begin
          slot_mem[r.dest][tail_ptr[r.dest]] = r.handle;
          tail_ptr[r.dest]++;
          depth_cnt[r.dest]++;
          o.status = mqrr_pkg::ST_OK;
        end
      end
      mqrr_pkg::OP_POP: begin
        if (!present_bits[r.dest]) begin
          o.status = mqrr_pkg::ST_BAD_DEST;
        end else if (depth_cnt[r.dest] == 0) begin
          o.status = mqrr_pkg::ST_EMPTY;
        end else begin
          o.popped = slot_mem[r.dest][head_ptr[r.dest]];
          head_ptr[r.dest]++;
          depth_cnt[r.dest]--;
          o.status = mqrr_pkg::ST_OK;
        end
      end
      mqrr_pkg::OP_PICK: begin
        // scan starts just after the last pick and ends on it
        o.status = mqrr_pkg::ST_EMPTY;
        for (k = 1; k <= N_DEST; k++) begin
          id = rr_last + 4'(k);
          if (o.status == mqrr_pkg::ST_EMPTY && worker_bits[id] && present_bits[id]
              && depth_cnt[id] != 0) begin
            rr_last  = id;
            o.picked = id;
            o.status = mqrr_pkg::ST_OK;
          end
        end
      end
      default: o.status = mqrr_pkg::ST_BAD_DEST;
    endcase
    due_rsp.insert(due_rsp.size(), o);
  endtask

  // request driver: one request per handshake, random gap before each
  always @(posedge clk_i) begin : drive_req
    logic     next_valid;
    req_rec_t r;
    int       gap_left;
    bit       calm;
    if (rst_ni) begin
      next_valid = req_valid;
      if (req_valid && req_if.ready) begin
        predict_dispatch('{op: req_op, dest: req_dest, handle: req_handle});
        holding_req = 1'b0;
        next_valid  = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_req.size() != 0) begin
          r = pending_req.pop_front();
          req_op      <= r.op;
          req_dest    <= r.dest;
          req_handle  <= r.handle;
          next_valid  = 1'b1;
          holding_req = 1'b1;
          // gap before the following request; calm stretches have none
          if ($urandom_range(0, 99) < 4) calm = !calm;
          gap_left = calm ? 0 : $urandom_range(0, 5);
        end
      end
      req_valid <= next_valid;
    end
  end

  // response monitor: compare each response with the oldest prediction
  always @(posedge clk_i) begin : watch_rsp
    rsp_rec_t want;
    int       stall_left;
    bit       calm;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                    rsp_if.status));
        end else begin
          want = due_rsp.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
          if (rsp_if.popped_handle !== want.popped)
            report_mismatch($sformatf("popped_handle %h, want %h",
                                      rsp_if.popped_handle, want.popped));
          if (rsp_if.picked_id !== want.picked)
            report_mismatch($sformatf("picked_id %0d, want %0d",
                                      rsp_if.picked_id, want.picked));
        end
        if ($urandom_range(0, 99) < 4) calm = !calm;
        stall_left = calm ? 0 : $urandom_range(0, 5);
      end
      // back-pressure: hold ready low for the drawn stall
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [mqrr_pkg::OPCODE_BITS-1:0] op,
                           input logic [mqrr_pkg::DEST_BITS-1:0] dest,
                           input logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] handle);
    pending_req.insert(pending_req.size(), '{op: op, dest: dest, handle: handle});
  endtask

  // wait until every request went out and every response came back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_req.size() != 0 || holding_req || due_rsp.size() != 0);
    repeat (DRAIN_TICKS) @(posedge clk_i);
  endtask

  // register write, only ever issued while the dispatcher is idle
  task automatic write_reg(input logic [mqrr_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [mqrr_pkg::MASK_BITS-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    if (idx == mqrr_pkg::CFG_PRESENT) present_bits = val;
    else if (idx == mqrr_pkg::CFG_WORKER) worker_bits = val;
  endtask

  // one phase of random traffic under a given mask setting
  task automatic run_phase(input logic [mqrr_pkg::MASK_BITS-1:0] present,
                           input logic [mqrr_pkg::MASK_BITS-1:0] worker,
                           input int n);
    logic [mqrr_pkg::DEST_BITS-1:0]        hot [3];
    logic [mqrr_pkg::OPCODE_BITS-1:0]      op;
    logic [mqrr_pkg::DEST_BITS-1:0]        dest;
    logic [mqrr_pkg::HANDLE_PORT_BITS-1:0] handle;
    int                                    push_pct, pop_pct, roll, i;
    write_reg(mqrr_pkg::CFG_PRESENT, present);
    write_reg(mqrr_pkg::CFG_WORKER, worker);
    // a few hot destinations so that queues fill up and wrap
    foreach (hot[j]) hot[j] = 4'($urandom_range(0, N_DEST - 1));
    push_pct = $urandom_range(30, 65);
    pop_pct  = $urandom_range(15, 90 - push_pct);
    for (i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) op = mqrr_pkg::OP_PUSH;
      else if (roll < push_pct + pop_pct) op = mqrr_pkg::OP_POP;
      else if (roll < 96) op = mqrr_pkg::OP_PICK;
      else op = OP_NONE;
      dest = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 2)]
                                         : 4'($urandom_range(0, N_DEST - 1));
      roll = $urandom_range(0, 9);
      if (roll == 0) handle = '0;
      else if (roll == 1) handle = '1;
      else handle = $urandom;
      queue_req(op, dest, handle);
    end
    wait_quiet();
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < N_DEST; i++) begin
      head_ptr[i]  = '0;
      tail_ptr[i]  = '0;
      depth_cnt[i] = '0;
    end
    rr_last      = '0;
    present_bits = '0;
    worker_bits  = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: d2 absent, d1 present, workers 0, 2 (absent) and 15
    write_reg(mqrr_pkg::CFG_PRESENT, 16'hA5F3);
    write_reg(mqrr_pkg::CFG_WORKER, 16'h8005);
    queue_req(mqrr_pkg::OP_PICK, 4'd0, '0);               // no busy worker
    queue_req(mqrr_pkg::OP_PUSH, 4'd2, 32'h1234_5678);    // push to absent queue
    queue_req(mqrr_pkg::OP_POP, 4'd2, '0);                // pop from absent queue
    queue_req(mqrr_pkg::OP_POP, 4'd1, '0);                // pop from empty queue
    queue_req(OP_NONE, 4'd0, '1);                         // unused opcode
    queue_req(mqrr_pkg::OP_PUSH, 4'd15, '1);
    queue_req(mqrr_pkg::OP_PICK, 4'd0, '0);               // wraps up to the top id
    for (i = 0; i < Q_DEPTH; i++)
      queue_req(mqrr_pkg::OP_PUSH, 4'd0, 32'h1111_1111 * i);
    queue_req(mqrr_pkg::OP_PUSH, 4'd0, 32'hDEAD_BEEF);    // queue full, dropped
    queue_req(mqrr_pkg::OP_PICK, 4'd0, '0);               // wraps from 15 to 0
    queue_req(mqrr_pkg::OP_POP, 4'd15, '0);
    queue_req(mqrr_pkg::OP_POP, 4'd0, '0);
    wait_quiet();

    // random part, mask extremes first; each boundary waits for a full drain
    run_phase(16'hFFFF, 16'hFFFF, 150);
    run_phase(16'h0000, 16'h0000, 60);
    run_phase(16'hFFFF, 16'h0000, 60);
    for (i = 0; i < 7; i++)
      run_phase(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)), 150);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
